FILE: hdl/tcce_pkg.sv
// Shared types, codes and the microcode table of the text console cursor engine.
package tcce_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_MAX_ROWS    = 256;
  localparam int unsigned DEF_TAB_WIDTH   = 8;

  // Field widths fixed by the interface.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_MIN = 8'h20;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 2'd0,
    REG_TEXT_COLUMNS = 2'd1,
    REG_TEXT_ROWS    = 2'd2,
    REG_GLYPH_LIMIT  = 2'd3
  } cfg_reg_t;

  // Cell command codes on the result channel.
  typedef enum logic [1:0] {
    CMD_DRAW         = 2'd0,
    CMD_ERASE_CURSOR = 2'd1,
    CMD_DRAW_CURSOR  = 2'd2,
    CMD_SCROLL       = 2'd3
  } cmd_t;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    S_ERASE   = 3'd0,
    S_NEWLINE = 3'd1,
    S_RETURN  = 3'd2,
    S_BACK    = 3'd3,
    S_TAB     = 3'd4,
    S_PRINT   = 3'd5,
    S_CURSOR  = 3'd6
  } step_t;

  // Character classes used by the dispatch jump.
  typedef enum logic [2:0] {
    CL_NEWLINE   = 3'd0,
    CL_RETURN    = 3'd1,
    CL_BACKSPACE = 3'd2,
    CL_TAB       = 3'd3,
    CL_PRINT     = 3'd4,
    CL_OTHER     = 3'd5
  } char_class_t;

  // When a step issues a command.
  typedef enum logic [1:0] {
    EM_NONE      = 2'd0,
    EM_ALWAYS    = 2'd1,
    EM_ON_SCROLL = 2'd2
  } emit_t;

  // Which cell a command addresses.
  typedef enum logic [1:0] {
    CELL_CURSOR = 2'd0,
    CELL_BACK   = 2'd1,
    CELL_ORIGIN = 2'd2
  } cell_sel_t;

  // Cursor update performed by a step.
  typedef enum logic [2:0] {
    CUR_HOLD    = 3'd0,
    CUR_NEWLINE = 3'd1,
    CUR_HOME    = 3'd2,
    CUR_BACK    = 3'd3,
    CUR_ADVANCE = 3'd4
  } cur_op_t;

  // Next-step selection.
  typedef enum logic [2:0] {
    BR_GOTO     = 3'd0,
    BR_DISPATCH = 3'd1,
    BR_WRAP     = 3'd2,
    BR_TAB      = 3'd3,
    BR_END      = 3'd4
  } branch_t;

  // One control word of the microprogram.
  typedef struct packed {
    emit_t     emit;
    cmd_t      cmd;
    cell_sel_t cell_sel;
    logic      glyph_char;
    logic      last;
    cur_op_t   cur_op;
    branch_t   br;
    step_t     target;
  } ctrl_word_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    char_class_t cls;
    logic        wrap;
    logic        tab_stop;
  } status_t;

  // Microcode ROM: one control word per step.
  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    unique case (s)
      S_ERASE:   w = '{EM_ALWAYS, CMD_ERASE_CURSOR, CELL_CURSOR, 1'b0, 1'b0,
                       CUR_HOLD, BR_DISPATCH, S_CURSOR};
      S_NEWLINE: w = '{EM_ON_SCROLL, CMD_SCROLL, CELL_ORIGIN, 1'b0, 1'b0,
                       CUR_NEWLINE, BR_GOTO, S_CURSOR};
      S_RETURN:  w = '{EM_NONE, CMD_DRAW, CELL_CURSOR, 1'b0, 1'b0,
                       CUR_HOME, BR_GOTO, S_CURSOR};
      S_BACK:    w = '{EM_ALWAYS, CMD_DRAW, CELL_BACK, 1'b0, 1'b0,
                       CUR_BACK, BR_GOTO, S_CURSOR};
      S_TAB:     w = '{EM_ALWAYS, CMD_DRAW, CELL_CURSOR, 1'b0, 1'b0,
                       CUR_ADVANCE, BR_TAB, S_TAB};
      S_PRINT:   w = '{EM_ALWAYS, CMD_DRAW, CELL_CURSOR, 1'b1, 1'b0,
                       CUR_ADVANCE, BR_WRAP, S_CURSOR};
      default:   w = '{EM_ALWAYS, CMD_DRAW_CURSOR, CELL_CURSOR, 1'b0, 1'b1,
                       CUR_HOLD, BR_END, S_CURSOR};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/tcce_channels.sv
// Channel interfaces: character input, cell command output and configuration writes.
interface tcce_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcce_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcce_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [tcce_pkg::POS_W-1:0] cell_column;
  logic [tcce_pkg::POS_W-1:0] cell_row;
  logic [tcce_pkg::CHAR_W-1:0] glyph;
  logic                       last;

  modport source (output valid, output command, output cell_column, output cell_row,
                  output glyph, output last, input ready);
  modport sink   (input valid, input command, input cell_column, input cell_row,
                  input glyph, input last, output ready);
endinterface

interface tcce_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcce_pkg::CFG_IDX_W-1:0] index;
  logic [tcce_pkg::SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: cursor datapath, registers and output stage.
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   char_code[7:0]
//   out_chan  out  valid/ready   command[1:0], cell_column[7:0], cell_row[7:0], glyph[7:0], last
//   cfg_chan  in   valid/ready   index[1:0], data[8:0] (always ready)
//
// A character is accepted and then runs through its microcode steps; a printable byte that wraps
// adds a newline step, and a tab repeats its step per column. The sequencer issues one control
// word per cycle while no step stalls, and each step moves at most one command into the output
// register. Reset is synchronous and active low; it clears the cursor and loads the defaults.
// A step that issues a command waits while the output register holds an untaken transfer.
// A new character is taken once the previous one has issued its final command.
module text_console_cursor_engine #(
  parameter int unsigned MAX_COLUMNS = tcce_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = tcce_pkg::DEF_MAX_ROWS,
  parameter int unsigned TAB_WIDTH   = tcce_pkg::DEF_TAB_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  tcce_in_if.sink      in_chan,
  tcce_out_if.source   out_chan,
  tcce_cfg_if.sink     cfg_chan
);

  localparam int unsigned POS_W  = tcce_pkg::POS_W;
  localparam int unsigned SIZE_W = tcce_pkg::SIZE_W;
  localparam int unsigned NCELLS = 1 << POS_W;
  localparam logic [SIZE_W-1:0] COL_TOP =
    SIZE_W'((MAX_COLUMNS < NCELLS) ? MAX_COLUMNS : NCELLS);
  localparam logic [SIZE_W-1:0] ROW_TOP =
    SIZE_W'((MAX_ROWS < NCELLS) ? MAX_ROWS : NCELLS);

  // Configuration registers.
  logic              enable_r;
  logic [SIZE_W-1:0] text_columns_r;
  logic [SIZE_W-1:0] text_rows_r;
  logic [SIZE_W-1:0] glyph_limit_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      text_columns_r <= SIZE_W'(80);
      text_rows_r    <= SIZE_W'(25);
      glyph_limit_r  <= SIZE_W'(256);
    end else if (cfg_chan.valid) begin
      unique case (tcce_pkg::cfg_reg_t'(cfg_chan.index))
        tcce_pkg::REG_ENABLE:       enable_r       <= cfg_chan.data[0];
        tcce_pkg::REG_TEXT_COLUMNS: text_columns_r <= cfg_chan.data;
        tcce_pkg::REG_TEXT_ROWS:    text_rows_r    <= cfg_chan.data;
        default:                    glyph_limit_r  <= cfg_chan.data;
      endcase
    end
  end

  // Grid size saturated to the supported range.
  logic [SIZE_W-1:0] cols_w, rows_w;
  always_comb begin
    priority if (text_columns_r == '0)     cols_w = SIZE_W'(1);
    else if (text_columns_r > COL_TOP)     cols_w = COL_TOP;
    else                                   cols_w = text_columns_r;
    priority if (text_rows_r == '0)        rows_w = SIZE_W'(1);
    else if (text_rows_r > ROW_TOP)        rows_w = ROW_TOP;
    else                                   rows_w = text_rows_r;
  end

  // Tab stop table: set where the column after this one is a multiple of the tab width.
  logic [NCELLS-1:0] tab_stop_tbl;
  for (genvar gi = 0; gi < NCELLS; gi++) begin : g_tab_stop
    assign tab_stop_tbl[gi] = (((gi + 1) % TAB_WIDTH) == 0);
  end

  // Input capture and sequencer start.
  logic                         busy;
  logic                         in_fire;
  logic [tcce_pkg::CHAR_W-1:0]  char_r;
  assign in_chan.ready = !busy;
  assign in_fire       = in_chan.valid && !busy;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_r <= in_chan.char_code;
    end
  end

  // Character classification.
  tcce_pkg::char_class_t cls_w;
  always_comb begin
    priority if (char_r == tcce_pkg::CHAR_NEWLINE)    cls_w = tcce_pkg::CL_NEWLINE;
    else if (char_r == tcce_pkg::CHAR_RETURN)         cls_w = tcce_pkg::CL_RETURN;
    else if (char_r == tcce_pkg::CHAR_BACKSPACE)      cls_w = tcce_pkg::CL_BACKSPACE;
    else if (char_r == tcce_pkg::CHAR_TAB)            cls_w = tcce_pkg::CL_TAB;
    else if (char_r >= tcce_pkg::CHAR_PRINT_MIN)      cls_w = tcce_pkg::CL_PRINT;
    else                                              cls_w = tcce_pkg::CL_OTHER;
  end

  // Cursor position and the moves derived from it.
  logic [POS_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [POS_W-1:0]  cursor_row_r, cursor_row_nxt;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              wrap, scroll;
  logic [POS_W-1:0]  nl_row, back_col, back_row;

  assign col_inc = {1'b0, cursor_col_r} + SIZE_W'(1);
  assign row_inc = {1'b0, cursor_row_r} + SIZE_W'(1);
  assign wrap    = (col_inc >= cols_w);
  assign scroll  = (row_inc >= rows_w);
  assign nl_row  = scroll ? POS_W'(rows_w - SIZE_W'(1)) : row_inc[POS_W-1:0];

  // Backspace target: previous column, the end of the previous row, or the origin itself.
  always_comb begin
    priority if (cursor_col_r != '0) begin
      back_col = cursor_col_r - POS_W'(1);
      back_row = cursor_row_r;
    end else if (cursor_row_r != '0) begin
      back_col = POS_W'(cols_w - SIZE_W'(1));
      back_row = cursor_row_r - POS_W'(1);
    end else begin
      back_col = cursor_col_r;
      back_row = cursor_row_r;
    end
  end

  // Microcode sequencer.
  tcce_pkg::ctrl_word_t ctrl;
  tcce_pkg::status_t    status;
  logic                 emit_now, stall, step_go;

  assign status = '{cls: cls_w, wrap: wrap, tab_stop: tab_stop_tbl[cursor_col_r]};

  tcce_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire && enable_r),
    .advance (!stall),
    .status  (status),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  always_comb begin
    unique case (ctrl.emit)
      tcce_pkg::EM_ALWAYS:    emit_now = 1'b1;
      tcce_pkg::EM_ON_SCROLL: emit_now = scroll;
      default:                emit_now = 1'b0;
    endcase
  end

  logic out_valid_r;
  assign stall   = emit_now && out_valid_r && !out_chan.ready;
  assign step_go = busy && !stall;

  // Cursor update for the current step.
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    if (step_go) begin
      unique case (ctrl.cur_op)
        tcce_pkg::CUR_NEWLINE: begin
          cursor_col_nxt = '0;
          cursor_row_nxt = nl_row;
        end
        tcce_pkg::CUR_HOME:    cursor_col_nxt = '0;
        tcce_pkg::CUR_BACK: begin
          cursor_col_nxt = back_col;
          cursor_row_nxt = back_row;
        end
        tcce_pkg::CUR_ADVANCE: cursor_col_nxt = col_inc[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  // Command fields for the current step.
  logic [POS_W-1:0]            cell_col_w, cell_row_w;
  logic [tcce_pkg::CHAR_W-1:0] glyph_w;
  always_comb begin
    unique case (ctrl.cell_sel)
      tcce_pkg::CELL_BACK: begin
        cell_col_w = back_col;
        cell_row_w = back_row;
      end
      tcce_pkg::CELL_ORIGIN: begin
        cell_col_w = '0;
        cell_row_w = '0;
      end
      default: begin
        cell_col_w = cursor_col_r;
        cell_row_w = cursor_row_r;
      end
    endcase
    if (ctrl.glyph_char && ({1'b0, char_r} < glyph_limit_r)) begin
      glyph_w = char_r;
    end else begin
      glyph_w = '0;
    end
  end

  // Output register.
  tcce_pkg::cmd_t              out_cmd_r;
  logic [POS_W-1:0]            out_col_r, out_row_r;
  logic [tcce_pkg::CHAR_W-1:0] out_glyph_r;
  logic                        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go && emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && emit_now) begin
      out_cmd_r   <= ctrl.cmd;
      out_col_r   <= cell_col_w;
      out_row_r   <= cell_row_w;
      out_glyph_r <= glyph_w;
      out_last_r  <= ctrl.last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.command     = out_cmd_r;
  assign out_chan.cell_column = out_col_r;
  assign out_chan.cell_row    = out_row_r;
  assign out_chan.glyph       = out_glyph_r;
  assign out_chan.last        = out_last_r;

  // A character taken while disabled starts no work.
  a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !enable_r) |=> !busy)
    else $error("disabled character started the sequencer");

  // The step that issues the final command ends the character.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && ctrl.last) |=> !busy)
    else $error("sequencer still busy after final command");

  // A newline always leaves the cursor on a visible row.
  a_newline_row: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && ctrl.cur_op == tcce_pkg::CUR_NEWLINE) |=>
      ({1'b0, cursor_row_r} < $past(rows_w)))
    else $error("cursor row beyond grid after newline");

  // An advance that does not wrap moves exactly one column right.
  a_advance_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && ctrl.cur_op == tcce_pkg::CUR_ADVANCE && !wrap) |=>
      (cursor_col_r == POS_W'($past(cursor_col_r) + POS_W'(1))))
    else $error("cursor advance moved by other than one column");

endmodule

FILE: hdl/tcce_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module tcce_useq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 advance,
  input  tcce_pkg::status_t    status,
  output tcce_pkg::ctrl_word_t ctrl,
  output logic                 busy
);

  logic                busy_r, busy_nxt;
  tcce_pkg::step_t     upc_r, upc_nxt;
  tcce_pkg::step_t     jump;

  // Control word of the current step.
  assign ctrl = tcce_pkg::ucode_rom(upc_r);
  assign busy = busy_r;

  // Dispatch on the character class.
  tcce_pkg::step_t dispatch;
  always_comb begin
    unique case (status.cls)
      tcce_pkg::CL_NEWLINE:   dispatch = tcce_pkg::S_NEWLINE;
      tcce_pkg::CL_RETURN:    dispatch = tcce_pkg::S_RETURN;
      tcce_pkg::CL_BACKSPACE: dispatch = tcce_pkg::S_BACK;
      tcce_pkg::CL_TAB:       dispatch = tcce_pkg::S_TAB;
      tcce_pkg::CL_PRINT:     dispatch = tcce_pkg::S_PRINT;
      default:                dispatch = tcce_pkg::S_CURSOR;
    endcase
  end

  // Next step address from the branch field.
  always_comb begin
    unique case (ctrl.br)
      tcce_pkg::BR_DISPATCH: jump = dispatch;
      tcce_pkg::BR_WRAP:     jump = status.wrap ? tcce_pkg::S_NEWLINE : ctrl.target;
      tcce_pkg::BR_TAB: begin
        priority if (status.wrap)     jump = tcce_pkg::S_NEWLINE;
        else if (status.tab_stop)     jump = tcce_pkg::S_CURSOR;
        else                          jump = ctrl.target;
      end
      default:               jump = ctrl.target;
    endcase
  end

  // Step counter update.
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = tcce_pkg::S_ERASE;
    end else if (busy_r && advance) begin
      if (ctrl.br == tcce_pkg::BR_END) begin
        busy_nxt = 1'b0;
      end else begin
        upc_nxt = jump;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= tcce_pkg::S_ERASE;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

FILE: sim/tb_text_console_cursor_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text console cursor engine.
module tb_text_console_cursor_engine;

  localparam int unsigned COL_TOP      =
    (tcce_pkg::DEF_MAX_COLUMNS < 256) ? tcce_pkg::DEF_MAX_COLUMNS : 256;
  localparam int unsigned ROW_TOP      =
    (tcce_pkg::DEF_MAX_ROWS < 256) ? tcce_pkg::DEF_MAX_ROWS : 256;
  localparam int unsigned TAB_STOP     = tcce_pkg::DEF_TAB_WIDTH;
  localparam int          SETTLE_TICKS = 2 * (tcce_pkg::DEF_TAB_WIDTH + 4);
  localparam int          HOLD_TICKS   = 80;
  localparam int          DIR_ROWS     = 38;
  localparam int          BLOCK_CHARS  = 14;

  // One cell command as it appears on the result channel.
  typedef struct packed {
    tcce_pkg::cmd_t command;
    logic [7:0]     cell_col;
    logic [7:0]     cell_row;
    logic [7:0]     glyph_idx;
    logic           last;
  } cell_cmd_t;

  typedef enum {ROW_CHAR, ROW_CFG} row_kind_t;

  // A directed row: a character, or a register write. A count of -1 means that
  // the commands come from the console model; otherwise they are typed in.
  typedef struct {
    row_kind_t          kind;
    tcce_pkg::cfg_reg_t reg_sel;
    logic [8:0]         value;
    int                 n_typed;
    cell_cmd_t [0:2]    typed;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tcce_in_if  in_chan ();
  tcce_out_if out_chan ();
  tcce_cfg_if cfg_chan ();

  text_console_cursor_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Console model state and register copies.
  int unsigned cur_col;
  int unsigned cur_row;
  logic        reg_enable;
  logic [8:0]  reg_cols;
  logic [8:0]  reg_rows;
  logic [8:0]  reg_glyphs;

  cell_cmd_t new_cmds[$];
  cell_cmd_t cmd_backlog[$];

  int err_count    = 0;
  int send_pct     = 0;
  int recv_pct     = 0;
  bit hold_request = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Disabled after reset: nothing comes out.
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h041, 0, '0},
    '{ROW_CFG,  tcce_pkg::REG_ENABLE, 9'h001, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h041, 3,
      '{'{tcce_pkg::CMD_ERASE_CURSOR, 8'd0, 8'd0, 8'd0, 1'b0},
        '{tcce_pkg::CMD_DRAW, 8'd0, 8'd0, 8'h41, 1'b0},
        '{tcce_pkg::CMD_DRAW_CURSOR, 8'd1, 8'd0, 8'd0, 1'b1}}},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h0FF, 3,
      '{'{tcce_pkg::CMD_ERASE_CURSOR, 8'd1, 8'd0, 8'd0, 1'b0},
        '{tcce_pkg::CMD_DRAW, 8'd1, 8'd0, 8'hFF, 1'b0},
        '{tcce_pkg::CMD_DRAW_CURSOR, 8'd2, 8'd0, 8'd0, 1'b1}}},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h000, 2,
      '{'{tcce_pkg::CMD_ERASE_CURSOR, 8'd2, 8'd0, 8'd0, 1'b0},
        '{tcce_pkg::CMD_DRAW_CURSOR, 8'd2, 8'd0, 8'd0, 1'b1}, '0}},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_RETURN}, 2,
      '{'{tcce_pkg::CMD_ERASE_CURSOR, 8'd2, 8'd0, 8'd0, 1'b0},
        '{tcce_pkg::CMD_DRAW_CURSOR, 8'd0, 8'd0, 8'd0, 1'b1}, '0}},
    // Backspace at the top-left cell clears it and stays put.
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_BACKSPACE}, 3,
      '{'{tcce_pkg::CMD_ERASE_CURSOR, 8'd0, 8'd0, 8'd0, 1'b0},
        '{tcce_pkg::CMD_DRAW, 8'd0, 8'd0, 8'd0, 1'b0},
        '{tcce_pkg::CMD_DRAW_CURSOR, 8'd0, 8'd0, 8'd0, 1'b1}}},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_TAB}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_PRINT_MIN}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_NEWLINE}, -1, '0},
    // Backspace across the line boundary, then a wrap at the last column.
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_BACKSPACE}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h07E, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h01F, -1, '0},
    // No glyphs available, then a limit above the code range.
    '{ROW_CFG,  tcce_pkg::REG_GLYPH_LIMIT, 9'h000, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h07E, -1, '0},
    '{ROW_CFG,  tcce_pkg::REG_GLYPH_LIMIT, 9'h1FF, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h0FF, -1, '0},
    // Grid sizes below range saturate to one cell; the cursor lies beyond it.
    '{ROW_CFG,  tcce_pkg::REG_TEXT_COLUMNS, 9'h000, -1, '0},
    '{ROW_CFG,  tcce_pkg::REG_TEXT_ROWS, 9'h000, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h041, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_NEWLINE}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_TAB}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_BACKSPACE}, -1, '0},
    // Grid sizes above range saturate to the full grid.
    '{ROW_CFG,  tcce_pkg::REG_TEXT_COLUMNS, 9'h1FF, -1, '0},
    '{ROW_CFG,  tcce_pkg::REG_TEXT_ROWS, 9'h1FF, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_BACKSPACE}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_NEWLINE}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_BACKSPACE}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h080, -1, '0},
    // A tab that runs into the row end and scrolls a two-row screen.
    '{ROW_CFG,  tcce_pkg::REG_TEXT_COLUMNS, 9'd10, -1, '0},
    '{ROW_CFG,  tcce_pkg::REG_TEXT_ROWS, 9'd2, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_TAB}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_TAB}, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, {1'b0, tcce_pkg::CHAR_NEWLINE}, -1, '0},
    '{ROW_CFG,  tcce_pkg::REG_GLYPH_LIMIT, 9'h100, -1, '0},
    // Only bit zero of the enable write counts.
    '{ROW_CFG,  tcce_pkg::REG_ENABLE, 9'h1FE, -1, '0},
    '{ROW_CHAR, tcce_pkg::REG_ENABLE, 9'h055, 0, '0},
    '{ROW_CFG,  tcce_pkg::REG_ENABLE, 9'h001, -1, '0}
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #6ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned fit_size(input logic [8:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void add_cmd(input tcce_pkg::cmd_t cmd, input int unsigned col,
                                  input int unsigned row, input logic [7:0] g,
                                  input logic last);
    cell_cmd_t c;
    c.command   = cmd;
    c.cell_col  = col[7:0];
    c.cell_row  = row[7:0];
    c.glyph_idx = g;
    c.last      = last;
    new_cmds.push_back(c);
  endfunction

  // Move to column 0 of the next row; scroll when that row is off the screen.
  function automatic void step_line(input int unsigned rows);
    cur_col = 0;
    cur_row = cur_row + 1;
    if (cur_row >= rows) begin
      add_cmd(tcce_pkg::CMD_SCROLL, 0, 0, 8'd0, 1'b0);
      cur_row = rows - 1;
    end
  endfunction

  // Cell commands caused by one character, left in new_cmds.
  function automatic void render_char(input logic [7:0] code);
    int unsigned cols;
    int unsigned rows;
    int unsigned stop;
    new_cmds.delete();
    if (!reg_enable) return;
    cols = fit_size(reg_cols, COL_TOP);
    rows = fit_size(reg_rows, ROW_TOP);
    add_cmd(tcce_pkg::CMD_ERASE_CURSOR, cur_col, cur_row, 8'd0, 1'b0);
    if (code == tcce_pkg::CHAR_NEWLINE) begin
      step_line(rows);
    end else if (code == tcce_pkg::CHAR_RETURN) begin
      cur_col = 0;
    end else if (code == tcce_pkg::CHAR_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col = cur_col - 1;
      end else if (cur_row > 0) begin
        cur_row = cur_row - 1;
        cur_col = cols - 1;
      end
      add_cmd(tcce_pkg::CMD_DRAW, cur_col, cur_row, 8'd0, 1'b0);
    end else if (code == tcce_pkg::CHAR_TAB) begin
      stop = cur_col - (cur_col % TAB_STOP) + TAB_STOP;
      while (cur_col < stop) begin
        add_cmd(tcce_pkg::CMD_DRAW, cur_col, cur_row, 8'd0, 1'b0);
        cur_col = cur_col + 1;
        if (cur_col >= cols) begin
          step_line(rows);
          break;
        end
      end
    end else if (code >= tcce_pkg::CHAR_PRINT_MIN) begin
      add_cmd(tcce_pkg::CMD_DRAW, cur_col, cur_row,
              ({1'b0, code} < reg_glyphs) ? code : 8'd0, 1'b0);
      cur_col = cur_col + 1;
      if (cur_col >= cols) step_line(rows);
    end
    add_cmd(tcce_pkg::CMD_DRAW_CURSOR, cur_col, cur_row, 8'd0, 1'b1);
  endfunction

  function automatic string show_cmd(input cell_cmd_t c);
    return $sformatf("cmd=%0d col=%0d row=%0d glyph=%0d last=%0b",
                     c.command, c.cell_col, c.cell_row, c.glyph_idx, c.last);
  endfunction

  task automatic report_fault(input string what);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Result checker: each transfer is matched against the oldest command due.
  always @(posedge clk) begin : result_check
    cell_cmd_t seen;
    cell_cmd_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.command   = tcce_pkg::cmd_t'(out_chan.command);
      seen.cell_col  = out_chan.cell_column;
      seen.cell_row  = out_chan.cell_row;
      seen.glyph_idx = out_chan.glyph;
      seen.last      = out_chan.last;
      if (cmd_backlog.size() == 0) begin
        report_fault({"unexpected command: ", show_cmd(seen)});
      end else begin
        want = cmd_backlog.pop_front();
        if (seen.command !== want.command || seen.cell_col !== want.cell_col ||
            seen.cell_row !== want.cell_row || seen.glyph_idx !== want.glyph_idx ||
            seen.last !== want.last) begin
          report_fault({"expected ", show_cmd(want), ", got ", show_cmd(seen)});
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_TICKS - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Offer one character with random gaps ahead of it and book its commands.
  task automatic push_char(input logic [7:0] code, input int n_typed,
                           input cell_cmd_t [0:2] typed);
    while ($urandom_range(99) < send_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= code;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    render_char(code);
    if (n_typed < 0) begin
      foreach (new_cmds[k]) cmd_backlog.push_back(new_cmds[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) cmd_backlog.push_back(typed[k]);
    end
  endtask

  // Stop sending and let every booked command come out, then let the block go quiet.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (cmd_backlog.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input tcce_pkg::cfg_reg_t sel, input logic [8:0] v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= sel;
    cfg_chan.data  <= v;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    unique case (sel)
      tcce_pkg::REG_ENABLE:       reg_enable = v[0];
      tcce_pkg::REG_TEXT_COLUMNS: reg_cols   = v;
      tcce_pkg::REG_TEXT_ROWS:    reg_rows   = v;
      default:                    reg_glyphs = v;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Grid sizes: mostly small screens so that wraps and scrolls are frequent.
  function automatic logic [8:0] pick_size();
    case ($urandom_range(7))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'($urandom_range(511, 257));
      4, 5:    return 9'($urandom_range(12, 2));
      6:       return 9'($urandom_range(255, 13));
      default: return 9'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return tcce_pkg::CHAR_NEWLINE;
    if (r < 25) return tcce_pkg::CHAR_RETURN;
    if (r < 35) return tcce_pkg::CHAR_BACKSPACE;
    if (r < 50) return tcce_pkg::CHAR_TAB;
    if (r < 90) return 8'($urandom_range(255, 32));
    return 8'($urandom_range(255));
  endfunction

  // Main stimulus.
  initial begin : stimulus
    cell_cmd_t [0:2] none;
    none = '0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.char_code = '0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = tcce_pkg::REG_ENABLE;
    cfg_chan.data     = '0;
    reg_enable        = 1'b0;
    reg_cols          = 9'd80;
    reg_rows          = 9'd25;
    reg_glyphs        = 9'd256;
    cur_col           = 0;
    cur_row           = 0;
    send_pct          = 29;
    recv_pct          = 87;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        push_char(dir_rows[i].value[7:0], dir_rows[i].n_typed, dir_rows[i].typed);
      end
    end

    // Random part: three idling phases, each with two register settings.
    for (int p = 0; p < 3; p++) begin
      send_pct = (p == 0) ? 29 : (p == 1) ? 87 : 0;
      recv_pct = (p == 0) ? 87 : (p == 1) ? 29 : 0;
      for (int b = 0; b < 2; b++) begin
        settle();
        write_reg(tcce_pkg::REG_TEXT_COLUMNS, pick_size());
        write_reg(tcce_pkg::REG_TEXT_ROWS, pick_size());
        if ($urandom_range(1)) begin
          write_reg(tcce_pkg::REG_GLYPH_LIMIT, 9'($urandom_range(256, 32)));
        end else begin
          write_reg(tcce_pkg::REG_GLYPH_LIMIT, 9'($urandom_range(511)));
        end
        write_reg(tcce_pkg::REG_ENABLE,
                  {8'($urandom_range(255)), ($urandom_range(99) < 85)});
        // Long receiver hold-off while characters keep coming.
        if (p == 2 && b == 0) hold_request = 1'b1;
        for (int n = 0; n < BLOCK_CHARS; n++) push_char(pick_char(), -1, none);
      end
    end

    settle();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
